FILE: rtl/bpu_pkg.sv
// Shared types and constants of the BMP pixel unpack and blit block.
// No dependencies; every other file of the block but bpu_ram imports this package.
`default_nettype none
package bpu_pkg;

  // Input word: palette write or one byte of the pixel array.
  typedef struct packed {
    logic        req_type;
    logic [7:0]  palette_slot;
    logic [31:0] palette_color;
    logic [7:0]  data_byte;
  } in_word_t;

  // Output word: one pixel with its screen position.
  typedef struct packed {
    logic [31:0] pixel_color;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        write_enable;
    logic        last_pixel;
  } out_word_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [2:0]  pixel_format;
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
    logic [1:0]  key_mode;
    logic [31:0] key_color;
    logic [31:0] substitute_color;
  } cfg_t;

  // Register indexes.
  localparam logic [2:0] REG_PIXEL_FORMAT     = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH      = 3'd1;
  localparam logic [2:0] REG_IMAGE_HEIGHT     = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X         = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Y         = 3'd4;
  localparam logic [2:0] REG_KEY_MODE         = 3'd5;
  localparam logic [2:0] REG_KEY_COLOR        = 3'd6;
  localparam logic [2:0] REG_SUBSTITUTE_COLOR = 3'd7;

  // Pixel format codes.
  localparam logic [2:0] FMT_4BPP  = 3'd0;
  localparam logic [2:0] FMT_8BPP  = 3'd1;
  localparam logic [2:0] FMT_16BPP = 3'd2;
  localparam logic [2:0] FMT_24BPP = 3'd3;
  localparam logic [2:0] FMT_32BPP = 3'd4;

  // Colour key modes.
  localparam logic [1:0] KEY_NORMAL      = 2'd0;
  localparam logic [1:0] KEY_TRANSPARENT = 2'd1;
  localparam logic [1:0] KEY_SUBSTITUTE  = 2'd2;

  // Request types.
  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_PIXEL   = 1'b1;

  // Where the colour of a decoded pixel comes from.
  typedef enum logic [1:0] {
    SRC_PALETTE,
    SRC_DIRECT,
    SRC_ZERO
  } src_e;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic        last;
  } pix_pos_t;

  // Decoded byte waiting for its palette data.
  typedef struct packed {
    src_e        src;
    logic        two;
    logic [23:0] color;
    pix_pos_t    pos0;
    pix_pos_t    pos1;
  } stage_t;

endpackage
`default_nettype wire

FILE: rtl/bpu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bpu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bpu_unpack.sv
// Byte unpacker: row and column counters, byte assembly, palette read issue
// and the decode stage register. Depends on bpu_pkg.
`default_nettype none
module bpu_unpack #(
  parameter int MAX_DIM       = 1024,
  parameter int PALETTE_DEPTH = 256,
  parameter int COORD_BITS    = 12
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire bpu_pkg::cfg_t                    cfg_i,
  input  wire logic                             take_i,
  input  wire logic [7:0]                       byte_i,
  output logic                                  rd_en_o,
  output logic [$clog2(PALETTE_DEPTH)-1:0]      rd_addr_a_o,
  output logic [$clog2(PALETTE_DEPTH)-1:0]      rd_addr_b_o,
  output logic                                  stage_valid_o,
  output bpu_pkg::stage_t                       stage_o,
  input  wire logic                             stage_adv_i
);
  import bpu_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [10:0] col_q, col_d;
  logic [10:0] row_q, row_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  pad_q, pad_d;
  logic [23:0] part_q, part_d;
  logic        stage_valid_q;
  stage_t      stage_q, st;

  function automatic logic [10:0] clamp_dim(input logic [10:0] v);
    if (v == 11'd0) return 11'd1;
    if (32'(v) > MAX_DIM) return 11'(MAX_DIM);
    return v;
  endfunction

  function automatic logic hits_end(input logic [10:0] cnt, input logic [10:0] lim);
    return ({1'b0, cnt} + 12'd1) >= {1'b0, lim};
  endfunction

  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  logic [10:0] w, h, col1;
  logic        row_end0, row_end1, last0, last1;
  logic [31:0] cmask, xs0, xs1, ys;
  logic [11:0] xm0, xm1, ym;
  logic [11:0] w_plus;
  logic [1:0]  row_bytes, pad_new;
  logic        emit, fin, fin_last;
  logic [10:0] col_next;
  logic [15:0] v16;

  always_comb begin
    w        = clamp_dim(cfg_i.image_width);
    h        = clamp_dim(cfg_i.image_height);
    col1     = col_q + 11'd1;
    row_end0 = hits_end(col_q, w);
    row_end1 = hits_end(col1, w);
    last0    = row_end0 && hits_end(row_q, h);
    last1    = row_end1 && hits_end(row_q, h);

    // Screen position, wrapped to the coordinate width.
    cmask = (32'd1 << COORD_BITS) - 32'd1;
    xs0   = (32'(cfg_i.origin_x) + 32'(col_q)) & cmask;
    xs1   = (32'(cfg_i.origin_x) + 32'(col1)) & cmask;
    ys    = (32'(cfg_i.origin_y) + 32'(h) - 32'd1 - 32'(row_q)) & cmask;
    xm0   = xs0[11:0];
    xm1   = xs1[11:0];
    ym    = ys[11:0];

    // Row padding to a 4-byte boundary.
    w_plus = {1'b0, w} + 12'd1;
    case (cfg_i.pixel_format)
      FMT_4BPP:  row_bytes = w_plus[2:1];
      FMT_8BPP:  row_bytes = w[1:0];
      FMT_16BPP: row_bytes = {w[0], 1'b0};
      FMT_24BPP: row_bytes = 2'(w[1:0] + {w[0], 1'b0});
      default:   row_bytes = 2'd0;
    endcase
    pad_new = 2'd0 - row_bytes;

    col_d    = col_q;
    row_d    = row_q;
    phase_d  = phase_q;
    pad_d    = pad_q;
    part_d   = part_q;
    emit     = 1'b0;
    fin      = row_end0;
    fin_last = last0;
    col_next = col1;
    rd_en_o  = 1'b0;
    rd_addr_a_o = '0;
    rd_addr_b_o = '0;
    v16      = '0;

    st.src       = SRC_DIRECT;
    st.two       = 1'b0;
    st.color     = '0;
    st.pos0.x    = xm0;
    st.pos0.y    = ym;
    st.pos0.last = last0;
    st.pos1.x    = xm1;
    st.pos1.y    = ym;
    st.pos1.last = last1;

    if (take_i && (cfg_i.pixel_format <= FMT_32BPP)) begin
      if (pad_q != 2'd0) begin
        // Drop a padding byte.
        pad_d = pad_q - 2'd1;
      end else begin
        case (cfg_i.pixel_format)
          FMT_4BPP: begin
            emit        = 1'b1;
            st.src      = SRC_PALETTE;
            st.two      = !row_end0;
            rd_en_o     = 1'b1;
            rd_addr_a_o = AW'(byte_i[7:4]);
            rd_addr_b_o = AW'(byte_i[3:0]);
            if (!row_end0) begin
              fin      = row_end1;
              fin_last = last1;
              col_next = col_q + 11'd2;
            end
          end
          FMT_8BPP: begin
            emit = 1'b1;
            if (32'(byte_i) < PALETTE_DEPTH) begin
              st.src      = SRC_PALETTE;
              rd_en_o     = 1'b1;
              rd_addr_a_o = byte_i[AW-1:0];
            end else begin
              st.src = SRC_ZERO;
            end
          end
          FMT_16BPP: begin
            if (phase_q == 2'd0) begin
              part_d  = {16'd0, byte_i};
              phase_d = 2'd1;
            end else begin
              v16      = {byte_i, part_q[7:0]};
              emit     = 1'b1;
              st.color = {expand5(v16[14:10]), expand5(v16[9:5]), expand5(v16[4:0])};
              phase_d  = 2'd0;
              part_d   = '0;
            end
          end
          FMT_24BPP: begin
            if (phase_q < 2'd2) begin
              part_d  = part_q | (24'(byte_i) << {phase_q, 3'b000});
              phase_d = phase_q + 2'd1;
            end else begin
              emit     = 1'b1;
              st.color = {byte_i, part_q[15:0]};
              phase_d  = 2'd0;
              part_d   = '0;
            end
          end
          default: begin
            if (phase_q < 2'd3) begin
              part_d  = part_q | (24'(byte_i) << {phase_q, 3'b000});
              phase_d = phase_q + 2'd1;
            end else begin
              emit     = 1'b1;
              st.color = part_q;
              phase_d  = 2'd0;
              part_d   = '0;
            end
          end
        endcase

        if (emit) begin
          if (fin) begin
            pad_d   = pad_new;
            col_d   = '0;
            row_d   = fin_last ? 11'd0 : row_q + 11'd1;
            phase_d = 2'd0;
            part_d  = '0;
          end else begin
            col_d = col_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      row_q         <= '0;
      phase_q       <= '0;
      pad_q         <= '0;
      part_q        <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
      pad_q   <= pad_d;
      part_q  <= part_d;
      if (take_i) begin
        stage_valid_q <= emit;
      end else if (stage_adv_i) begin
        stage_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && emit) begin
      stage_q <= st;
    end
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

endmodule
`default_nettype wire

FILE: rtl/bpu_outq.sv
// Four-entry output queue that takes up to two pixels a cycle and releases
// one while out_stall_i is low. Depends on bpu_pkg.
`default_nettype none
module bpu_outq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         push_n_i,
  input  wire bpu_pkg::out_word_t word0_i,
  input  wire bpu_pkg::out_word_t word1_i,
  output logic [2:0]              free_o,
  output logic                    out_valid_o,
  output bpu_pkg::out_word_t      out_word_o,
  input  wire logic               out_stall_i
);
  import bpu_pkg::*;

  out_word_t   slot_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q, wr_ptr1;
  logic [2:0]  cnt_q;
  logic        pop;

  assign pop         = (cnt_q != 3'd0) && !out_stall_i;
  assign wr_ptr1     = wr_ptr_q + 2'd1;
  assign free_o      = 3'd4 - cnt_q;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_word_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      slot_q[wr_ptr_q] <= word0_i;
    end
    if (push_n_i == 2'd2) begin
      slot_q[wr_ptr1] <= word1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n_i;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, push_n_i} - {2'b00, pop};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bmp_pixel_unpack_blit_top.sv
// Top level of the BMP pixel unpack and blit block: configuration registers,
// two palette RAM copies, colour keying and the output queue.
// Depends on bpu_pkg, bpu_ram, bpu_unpack and bpu_outq.
//
//   channel  direction  handshake               word
//   in       input      in_valid_i / in_stall_o  bpu_pkg::in_word_t
//   out      output     out_valid_o / out_stall_i bpu_pkg::out_word_t
//   cfg      input      cfg_valid_i / cfg_ready_o index 3 bits, data 32 bits
//
// One input word is taken per cycle while in_stall_o is low. A pixel's
// byte goes into the decode stage register as its palette RAM read issues,
// then is keyed into the queue. The output port releases one pixel a cycle
// while out_stall_i is low, so at sustained rate 4 bpp bytes stall the input.
// Reset loads the register reset values and clears counters and the queue;
// the palette RAMs are not cleared and hold nothing until written.
// Input stalls only when the decode stage cannot move into the queue.
`default_nettype none
module bmp_pixel_unpack_blit_top #(
  parameter int MAX_DIM       = 1024,
  parameter int PALETTE_DEPTH = 256,
  parameter int COORD_BITS    = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire bpu_pkg::in_word_t  in_word_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  output bpu_pkg::out_word_t      out_word_o,
  input  wire logic               out_stall_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  import bpu_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  cfg_t cfg_q;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format     <= FMT_24BPP;
      cfg_q.image_width      <= 11'd1;
      cfg_q.image_height     <= 11'd1;
      cfg_q.origin_x         <= '0;
      cfg_q.origin_y         <= '0;
      cfg_q.key_mode         <= KEY_NORMAL;
      cfg_q.key_color        <= '0;
      cfg_q.substitute_color <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PIXEL_FORMAT:     cfg_q.pixel_format     <= cfg_data_i[2:0];
        REG_IMAGE_WIDTH:      cfg_q.image_width      <= cfg_data_i[10:0];
        REG_IMAGE_HEIGHT:     cfg_q.image_height     <= cfg_data_i[10:0];
        REG_ORIGIN_X:         cfg_q.origin_x         <= cfg_data_i[9:0];
        REG_ORIGIN_Y:         cfg_q.origin_y         <= cfg_data_i[9:0];
        REG_KEY_MODE:         cfg_q.key_mode         <= cfg_data_i[1:0];
        REG_KEY_COLOR:        cfg_q.key_color        <= cfg_data_i;
        REG_SUBSTITUTE_COLOR: cfg_q.substitute_color <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input handshake.
  logic in_acc, take_pixel;
  logic pal_we;
  logic [AW-1:0] pal_waddr;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign take_pixel = in_acc && (in_word_i.req_type == REQ_PIXEL);
  // Drop palette writes to slots beyond the store. A read issued the cycle
  // after a write already sees it, so no forwarding is needed.
  assign pal_we     = in_acc && (in_word_i.req_type == REQ_PALETTE)
                      && (32'(in_word_i.palette_slot) < PALETTE_DEPTH);
  assign pal_waddr  = in_word_i.palette_slot[AW-1:0];

  // Decode stage.
  logic          rd_en, stage_valid, stage_adv;
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  stage_t        stage;

  bpu_unpack #(
    .MAX_DIM       (MAX_DIM),
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .COORD_BITS    (COORD_BITS)
  ) u_unpack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .take_i        (take_pixel),
    .byte_i        (in_word_i.data_byte),
    .rd_en_o       (rd_en),
    .rd_addr_a_o   (rd_addr_a),
    .rd_addr_b_o   (rd_addr_b),
    .stage_valid_o (stage_valid),
    .stage_o       (stage),
    .stage_adv_i   (stage_adv)
  );

  // Two palette copies so both nibbles of a 4 bpp byte look up at once;
  // the reserved top byte is never stored.
  logic [23:0] pal_a, pal_b;

  bpu_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal_a (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (in_word_i.palette_color[23:0]),
    .re_i    (rd_en),
    .raddr_i (rd_addr_a),
    .rdata_o (pal_a)
  );

  bpu_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal_b (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (in_word_i.palette_color[23:0]),
    .re_i    (rd_en),
    .raddr_i (rd_addr_b),
    .rdata_o (pal_b)
  );

  // Colour keying.
  function automatic out_word_t apply_key(input logic [23:0] c24, input pix_pos_t pos,
                                          input cfg_t cfg);
    out_word_t o;
    logic      hit;
    hit            = ({8'd0, c24} == cfg.key_color);
    o.pixel_color  = {8'd0, c24};
    o.pixel_x      = pos.x;
    o.pixel_y      = pos.y;
    o.write_enable = 1'b1;
    o.last_pixel   = pos.last;
    if (hit && (cfg.key_mode == KEY_TRANSPARENT)) o.write_enable = 1'b0;
    if (hit && (cfg.key_mode == KEY_SUBSTITUTE))  o.pixel_color  = cfg.substitute_color;
    return o;
  endfunction

  logic [23:0] color0;
  out_word_t   word0, word1;
  logic [1:0]  need;
  logic [2:0]  free;

  always_comb begin
    case (stage.src)
      SRC_PALETTE: color0 = pal_a;
      SRC_DIRECT:  color0 = stage.color;
      default:     color0 = '0;
    endcase
    word0 = apply_key(color0, stage.pos0, cfg_q);
    word1 = apply_key(pal_b, stage.pos1, cfg_q);
  end

  // Advance the decode stage only when the queue has room for all its pixels.
  assign need       = stage.two ? 2'd2 : 2'd1;
  assign stage_adv  = stage_valid && (free >= {1'b0, need});
  assign in_stall_o = stage_valid && !stage_adv;

  bpu_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (stage_adv ? need : 2'd0),
    .word0_i     (word0),
    .word1_i     (word1),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule
`default_nettype wire

FILE: verif/bmp_pixel_unpack_blit_top_test.sv
// Self-checking testbench for bmp_pixel_unpack_blit_top: palette and pixel-array words in,
// decoded and colour-keyed pixels out, checked against an in-bench decoder.
// Depends on bpu_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module bmp_pixel_unpack_blit_top_test;
  import bpu_pkg::*;

  localparam int MAX_DIM       = 1024;
  localparam int SETTLE_CYCLES = 8;        // pipeline is two deep; allow margin
  localparam int RANDOM_WORDS  = 1100;
  localparam int LONG_HOLD     = 400;      // cycles of receiver back-pressure
  localparam int MAX_REPORTS   = 60;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int FMT_CODES     = 8;        // codes above FMT_32BPP are spare
  localparam logic [1:0] KEY_SPARE = 2'd3; // spare key mode, behaves as normal

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_word_t    in_word_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_word_t   out_word_o;
  logic        cfg_ready_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bmp_pixel_unpack_blit_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Decoder state: a private copy of the registers, counters and palette
  // ---------------------------------------------------------------------------
  logic [2:0]  img_format  = FMT_24BPP;
  logic [10:0] img_width   = 11'd1;
  logic [10:0] img_height  = 11'd1;
  logic [9:0]  img_left    = '0;
  logic [9:0]  img_top     = '0;
  logic [1:0]  key_mode    = KEY_NORMAL;
  logic [31:0] key_colour  = '0;
  logic [31:0] subst_colour = '0;

  logic [10:0] column      = '0;
  logic [10:0] row         = '0;
  logic [1:0]  byte_phase  = '0;
  logic [1:0]  pad_left    = '0;
  logic [23:0] partial     = '0;
  logic [31:0] palette [256];

  out_word_t   expected_pixels [$];   // pixels the block still owes us
  in_word_t    pending_words [$];     // stimulus not yet offered

  int words_queued = 0;
  int words_taken  = 0;
  int pixels_seen  = 0;
  int mismatches   = 0;

  // Dimensions of zero count as one; anything above MAX_DIM is clipped.
  function automatic logic [31:0] image_extent(input logic [10:0] v);
    if (v == 0) return 32'd1;
    if (v > MAX_DIM) return 32'(MAX_DIM);
    return 32'(v);
  endfunction

  // The reserved top byte of a palette entry never reaches a pixel.
  function automatic logic [31:0] palette_colour(input logic [7:0] idx);
    return {8'h00, palette[idx][23:0]};
  endfunction

  // 5-bit channel to 8 bits by repeating the top bits into the bottom.
  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  // Key, position and queue one pixel, then step the column/row counters.
  task automatic place_pixel(input logic [31:0] colour, output bit row_end);
    logic [31:0] w, h, x, y, row_bytes;
    bit          last;
    out_word_t   px;
    w        = image_extent(img_width);
    h        = image_extent(img_height);
    x        = img_left + column;
    y        = img_top + h - 1 - row;
    row_end  = (column + 32'd1) >= w;
    last     = row_end && ((row + 32'd1) >= h);
    px.pixel_color  = colour;
    px.write_enable = 1'b1;
    if (key_mode == KEY_TRANSPARENT && colour == key_colour) px.write_enable = 1'b0;
    if (key_mode == KEY_SUBSTITUTE && colour == key_colour) px.pixel_color = subst_colour;
    px.pixel_x    = x[11:0];
    px.pixel_y    = y[11:0];
    px.last_pixel = last;
    expected_pixels.push_back(px);
    if (row_end) begin
      case (img_format)
        FMT_4BPP:  row_bytes = (w + 1) >> 1;
        FMT_8BPP:  row_bytes = w;
        FMT_16BPP: row_bytes = 2 * w;
        FMT_24BPP: row_bytes = 3 * w;
        default:   row_bytes = 4 * w;
      endcase
      // rows are padded up to a multiple of four bytes
      pad_left   = 2'd0 - row_bytes[1:0];
      column     = '0;
      row        = last ? 11'd0 : row + 11'd1;
      byte_phase = '0;
      partial    = '0;
    end else begin
      column = column + 11'd1;
    end
  endtask

  // Work out what one accepted word produces.
  task automatic decode_word(input in_word_t w);
    logic [7:0]  b;
    logic [15:0] v;
    bit          row_end;
    b = w.data_byte;
    if (w.req_type == REQ_PALETTE) begin
      palette[w.palette_slot] = w.palette_color;
    end else if (img_format > FMT_32BPP) begin
      // spare format: swallow the byte, leave state alone
    end else if (pad_left != 0) begin
      pad_left = pad_left - 2'd1;
    end else begin
      case (img_format)
        FMT_4BPP: begin
          // high nibble first; a row ending here turns the low nibble into padding
          place_pixel(palette_colour({4'h0, b[7:4]}), row_end);
          if (!row_end) place_pixel(palette_colour({4'h0, b[3:0]}), row_end);
        end
        FMT_8BPP: place_pixel(palette_colour(b), row_end);
        FMT_16BPP: begin
          if (byte_phase == 0) begin
            partial    = {16'h0, b};
            byte_phase = 2'd1;
          end else begin
            v = {b, partial[7:0]};
            place_pixel({8'h00, expand5(v[14:10]), expand5(v[9:5]), expand5(v[4:0])},
                        row_end);
            byte_phase = '0;
            partial    = '0;
          end
        end
        FMT_24BPP: begin
          if (byte_phase < 2) begin
            partial    = partial | (24'(b) << (8 * byte_phase));
            byte_phase = byte_phase + 2'd1;
          end else begin
            place_pixel({8'h00, b, partial[15:0]}, row_end);
            byte_phase = '0;
            partial    = '0;
          end
        end
        default: begin
          // 32 bpp: the fourth byte is alpha and is dropped
          if (byte_phase < 3) begin
            partial    = partial | (24'(b) << (8 * byte_phase));
            byte_phase = byte_phase + 2'd1;
          end else begin
            place_pixel({8'h00, partial}, row_end);
            byte_phase = '0;
            partial    = '0;
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch, pixel %0d: %s", $time,
                                            pixels_seen, what);
  endtask

  task automatic check_pixel(input out_word_t got);
    out_word_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("colour %h at (%0d,%0d) with nothing pending",
                                got.pixel_color, got.pixel_x, got.pixel_y));
    end else begin
      want = expected_pixels.pop_front();
      if (got.pixel_color !== want.pixel_color)
        report_mismatch($sformatf("pixel_color %h, want %h", got.pixel_color, want.pixel_color));
      if (got.pixel_x !== want.pixel_x)
        report_mismatch($sformatf("pixel_x %0d, want %0d", got.pixel_x, want.pixel_x));
      if (got.pixel_y !== want.pixel_y)
        report_mismatch($sformatf("pixel_y %0d, want %0d", got.pixel_y, want.pixel_y));
      if (got.write_enable !== want.write_enable)
        report_mismatch($sformatf("write_enable %b, want %b", got.write_enable,
                                  want.write_enable));
      if (got.last_pixel !== want.last_pixel)
        report_mismatch($sformatf("last_pixel %b, want %b", got.last_pixel, want.last_pixel));
    end
    pixels_seen++;
  endtask

  // Per-word wait drawn at random; each run of words is either idling or
  // flat-out, chosen at random, so that both calm and busy stretches occur.
  function automatic int draw_wait(inout int run_left, inout bit idle_on);
    if (run_left <= 0) begin
      run_left = $urandom_range(20, 150);
      idle_on  = ($urandom_range(0, 3) != 0);
    end
    run_left--;
    return idle_on ? $urandom_range(0, 10) : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued words, hold each until taken, decode on acceptance
  // ---------------------------------------------------------------------------
  int send_wait     = 0;
  int send_run_left = 0;
  bit send_idle_on  = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_word(in_word_i);
        words_taken++;
      end
      // slot is free when nothing is offered or the offered word was just taken
      if (!in_valid_i || !in_stall_o) begin
        if (send_wait != 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_word_i  <= pending_words.pop_front();
          in_valid_i <= 1'b1;
          send_wait  = draw_wait(send_run_left, send_idle_on);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take pixels, check them, and stall at random or for a long hold
  // ---------------------------------------------------------------------------
  int recv_wait     = 0;
  int recv_run_left = 0;
  bit recv_idle_on  = 1'b0;
  int hold_left     = 0;
  bit hold_req      = 1'b0;   // toggled by the stimulus to ask for a long hold
  bit hold_ack      = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_pixel(out_word_o);
        recv_wait = draw_wait(recv_run_left, recv_idle_on);
      end
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    in_word_t w;
    w.req_type      = REQ_PIXEL;
    w.palette_slot  = 8'($urandom);   // don't-care fields still toggle
    w.palette_color = $urandom;
    w.data_byte     = b;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_palette(input logic [7:0] slot, input logic [31:0] colour);
    in_word_t w;
    w.req_type      = REQ_PALETTE;
    w.palette_slot  = slot;
    w.palette_color = colour;
    w.data_byte     = 8'($urandom);
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Bias towards flat black and white so that key colours actually match.
  function automatic logic [7:0] pixel_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h00;
      3, 4, 5: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Write one register; call at a rising edge. Leaves valid high so that
  // back-to-back writes need no second assignment in the same step.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_PIXEL_FORMAT:     img_format   = data[2:0];
      REG_IMAGE_WIDTH:      img_width    = data[10:0];
      REG_IMAGE_HEIGHT:     img_height   = data[10:0];
      REG_ORIGIN_X:         img_left     = data[9:0];
      REG_ORIGIN_Y:         img_top      = data[9:0];
      REG_KEY_MODE:         key_mode     = data[1:0];
      REG_KEY_COLOR:        key_colour   = data;
      REG_SUBSTITUTE_COLOR: subst_colour = data;
      default: ;
    endcase
  endtask

  task automatic set_image(input logic [2:0] fmt, input logic [10:0] width, height,
                           input logic [9:0] left, top, input logic [1:0] mode,
                           input logic [31:0] key, subst);
    cfg_write(REG_PIXEL_FORMAT, 32'(fmt));
    cfg_write(REG_IMAGE_WIDTH, 32'(width));
    cfg_write(REG_IMAGE_HEIGHT, 32'(height));
    cfg_write(REG_ORIGIN_X, 32'(left));
    cfg_write(REG_ORIGIN_Y, 32'(top));
    cfg_write(REG_KEY_MODE, 32'(mode));
    cfg_write(REG_KEY_COLOR, key);
    cfg_write(REG_SUBSTITUTE_COLOR, subst);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every queued word is taken and every pixel has come out, then
  // let the pipeline drain of words that give no pixel (padding, palette).
  task automatic wait_idle();
    while (words_taken != words_queued || expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] colour, key;
    logic [2:0]  fmt;
    logic [10:0] width, height;
    logic [9:0]  left, top;
    int          n, phase, random_words;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: 24 bpp, a 1x1 image, one padding byte per row.
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h80); push_byte(8'h5A);
    wait_idle();

    // Fill the whole palette before anything reads it. Slot 0 carries only a
    // reserved byte, so it decodes to black.
    for (int i = 0; i < 256; i++) begin
      case (i)
        0:       colour = 32'hFF00_0000;
        15:      colour = 32'h00FF_FFFF;
        255:     colour = 32'hFFFF_FFFF;
        default: colour = $urandom;
      endcase
      push_palette(8'(i), colour);
    end
    wait_idle();

    // 4 bpp, odd width: the second byte ends the row on its high nibble.
    // Transparent key on black, origin at the far corner.
    set_image(FMT_4BPP, 11'd3, 11'd2, 10'd1023, 10'd1023, KEY_TRANSPARENT, 32'h0,
              32'hFFFF_FFFF);
    push_byte(8'h0F); push_byte(8'hF0); push_byte(8'hA5); push_byte(8'h3C);
    push_byte(8'h10); push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF);
    wait_idle();

    // 8 bpp, width written as zero; top palette entry is keyed and replaced.
    set_image(FMT_8BPP, 11'd0, 11'd1, 10'd0, 10'd0, KEY_SUBSTITUTE, 32'h00FF_FFFF,
              32'h0012_3456);
    push_byte(8'hFF); push_byte(8'h11); push_byte(8'h22); push_byte(8'h33);
    wait_idle();

    // 16 bpp with bit 15 set, then pure red; spare key mode acts as normal.
    set_image(FMT_16BPP, 11'd1, 11'd1, 10'd800, 10'd600, KEY_SPARE, 32'h00FF_FFFF, 32'h0);
    push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h00); push_byte(8'h00);
    push_byte(8'h00); push_byte(8'h7C); push_byte(8'hFF); push_byte(8'hFF);
    wait_idle();

    // 32 bpp, oversize dimensions clip to MAX_DIM; alpha byte dropped.
    set_image(FMT_32BPP, 11'd2047, 11'd2047, 10'd0, 10'd1023, KEY_NORMAL, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    push_byte(8'h11); push_byte(8'h22); push_byte(8'h33); push_byte(8'hAB);
    wait_idle();

    // Spare format codes swallow bytes without touching the counters.
    for (int f = FMT_32BPP + 1; f < FMT_CODES; f++) begin
      cfg_write(REG_PIXEL_FORMAT, 32'(f));
      cfg_valid_i <= 1'b0;
      push_byte(8'($urandom));
      wait_idle();
    end

    // Random phases: fresh settings each time, counters carried across so that
    // images are often cut short or resized part way through.
    phase        = 0;
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      phase++;
      n   = $urandom_range(40, 120);
      fmt = ($urandom_range(0, 19) < 18) ? 3'($urandom_range(0, 4))
                                         : 3'($urandom_range(FMT_32BPP + 1, FMT_CODES - 1));
      case ($urandom_range(0, 19))
        0:       width = '0;
        1:       width = 11'(MAX_DIM);
        2:       width = 11'($urandom_range(MAX_DIM + 1, 2047));
        default: width = 11'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 19))
        0:       height = '0;
        1:       height = 11'(MAX_DIM);
        2:       height = 11'($urandom_range(MAX_DIM + 1, 2047));
        default: height = 11'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 7))
        0:       left = '0;
        1:       left = 10'd1023;
        default: left = 10'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 7))
        0:       top = '0;
        1:       top = 10'd1023;
        default: top = 10'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 6))
        0:       key = 32'h0;
        1:       key = 32'h00FF_FFFF;
        2:       key = palette_colour(8'h00);
        3:       key = palette_colour(8'h0F);
        4:       key = palette_colour(8'hFF);
        5:       key = 32'hFFFF_FFFF;
        default: key = $urandom;
      endcase
      // Two long phases at one pixel per byte: the receiver holds off while
      // the sender keeps offering, so the block fills and stalls its input.
      if (phase == 2 || phase == 9) begin
        fmt = FMT_8BPP;
        n   = 250;
      end
      set_image(fmt, width, height, left, top, 2'($urandom_range(0, 3)), key,
                ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) push_palette(8'($urandom), $urandom);
        else push_byte(pixel_byte());
      end
      if (phase == 2 || phase == 9) hold_req <= ~hold_req;
      if (fmt <= FMT_32BPP) random_words += n;
      wait_idle();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legitimate run.
  initial begin
    #TIMEOUT_NS;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
